[rtl/assert_macros.svh]
// Concurrent assertion helpers used by the checker file qfa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on ck and switched off while rs is high.
`define QFA_ASSERT(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed: %m");

// Assertion that also holds through reset.
`define QFA_ASSERT_ALWAYS(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("assertion failed: %m");

`endif

[rtl/qfa_pkg.sv]
`timescale 1ns / 1ps

package qfa_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int MAT_WIDTH  = DATA_WIDTH + 2;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH  = 2 * DATA_WIDTH + 4;
  localparam int RND_WIDTH  = SUM_WIDTH - FRAC_BITS;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_ROTATE = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_DOT    = 3'd4,
    OP_SCALE  = 3'd5,
    OP_NEGATE = 3'd6,
    OP_NONE   = 3'd7
  } qfa_op_t;

  typedef logic signed [DATA_WIDTH-1:0] qfa_data_t;
  typedef logic signed [MAT_WIDTH-1:0]  qfa_mat_t;
  typedef logic signed [PROD_WIDTH-1:0] qfa_prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  qfa_sum_t;
  typedef logic signed [RND_WIDTH-1:0]  qfa_rnd_t;

  typedef struct packed {
    qfa_op_t   operation;
    qfa_data_t a_x;
    qfa_data_t a_y;
    qfa_data_t a_z;
    qfa_data_t a_w;
    qfa_data_t b_x;
    qfa_data_t b_y;
    qfa_data_t b_z;
    qfa_data_t b_w;
  } qfa_req_t;

  typedef struct packed {
    qfa_data_t r_x;
    qfa_data_t r_y;
    qfa_data_t r_z;
    qfa_data_t r_w;
    logic      overflow;
  } qfa_res_t;

  // Second pipeline stage: full precision sums plus what later stages need.
  typedef struct packed {
    logic                valid;
    qfa_op_t             operation;
    qfa_sum_t [8:0]      sums;
    qfa_data_t           b_x;
    qfa_data_t           b_y;
    qfa_data_t           b_z;
    qfa_res_t            simple;
  } qfa_sum_stage_t;

  typedef struct packed {
    qfa_data_t value;
    logic      ovf;
  } qfa_sat_t;

  typedef struct packed {
    qfa_mat_t value;
    logic     ovf;
  } qfa_mat_sat_t;

  localparam qfa_sum_t ROUND_HALF = SUM_WIDTH'(2 ** (FRAC_BITS - 1));
  localparam qfa_rnd_t DATA_MAX_R = RND_WIDTH'(2 ** (DATA_WIDTH - 1) - 1);
  localparam qfa_rnd_t DATA_MIN_R = RND_WIDTH'(-(2 ** (DATA_WIDTH - 1)));
  localparam qfa_rnd_t MAT_MAX_R  = RND_WIDTH'(2 ** (MAT_WIDTH - 1) - 1);
  localparam qfa_rnd_t MAT_MIN_R  = RND_WIDTH'(-(2 ** (MAT_WIDTH - 1)));

  function automatic qfa_rnd_t round_half_up(qfa_sum_t v);
    qfa_sum_t t;
    t = v + ROUND_HALF;
    return t[SUM_WIDTH-1:FRAC_BITS];
  endfunction

  function automatic qfa_sat_t sat_data(qfa_rnd_t v);
    qfa_sat_t s;
    if (v > DATA_MAX_R) begin
      s.value = DATA_MAX_R[DATA_WIDTH-1:0];
      s.ovf   = 1'b1;
    end else if (v < DATA_MIN_R) begin
      s.value = DATA_MIN_R[DATA_WIDTH-1:0];
      s.ovf   = 1'b1;
    end else begin
      s.value = v[DATA_WIDTH-1:0];
      s.ovf   = 1'b0;
    end
    return s;
  endfunction

  function automatic qfa_mat_sat_t sat_mat(qfa_rnd_t v);
    qfa_mat_sat_t s;
    if (v > MAT_MAX_R) begin
      s.value = MAT_MAX_R[MAT_WIDTH-1:0];
      s.ovf   = 1'b1;
    end else if (v < MAT_MIN_R) begin
      s.value = MAT_MIN_R[MAT_WIDTH-1:0];
      s.ovf   = 1'b1;
    end else begin
      s.value = v[MAT_WIDTH-1:0];
      s.ovf   = 1'b0;
    end
    return s;
  endfunction

endpackage

[rtl/qfa_prod_sum.sv]
`timescale 1ns / 1ps

module qfa_prod_sum (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   req_valid,
  input  qfa_pkg::qfa_req_t      req,
  output qfa_pkg::qfa_sum_stage_t sums
);
  import qfa_pkg::*;

  qfa_data_t a_vec [4];
  qfa_data_t b_vec [4];
  qfa_data_t o_vec [4];
  qfa_prod_t prod_next [16];
  qfa_rnd_t  wide [4];
  qfa_sat_t  wsat [4];
  qfa_res_t  simple_next;

  logic      valid1;
  qfa_op_t   op1;
  qfa_prod_t prod1 [16];
  qfa_data_t b1 [3];
  qfa_res_t  simple1;

  qfa_sum_t       pe [16];
  qfa_sum_stage_t sums_next;

  // stage 1: product array, a times b, or a times a for rotate
  always_comb begin
    a_vec[0] = req.a_x;
    a_vec[1] = req.a_y;
    a_vec[2] = req.a_z;
    a_vec[3] = req.a_w;
    b_vec[0] = req.b_x;
    b_vec[1] = req.b_y;
    b_vec[2] = req.b_z;
    b_vec[3] = req.b_w;
    if (req.operation == OP_ROTATE) begin
      o_vec = a_vec;
    end else begin
      o_vec = b_vec;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[4*i+j] = qfa_prod_t'(a_vec[i]) * qfa_prod_t'(o_vec[j]);
      end
    end
  end

  // add, sub, negate finish here
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (req.operation)
        OP_ADD:    wide[k] = qfa_rnd_t'(a_vec[k]) + qfa_rnd_t'(b_vec[k]);
        OP_SUB:    wide[k] = qfa_rnd_t'(a_vec[k]) - qfa_rnd_t'(b_vec[k]);
        OP_NEGATE: wide[k] = -qfa_rnd_t'(a_vec[k]);
        default:   wide[k] = '0;
      endcase
      wsat[k] = sat_data(wide[k]);
    end
    simple_next.r_x      = wsat[0].value;
    simple_next.r_y      = wsat[1].value;
    simple_next.r_z      = wsat[2].value;
    simple_next.r_w      = wsat[3].value;
    simple_next.overflow = wsat[0].ovf | wsat[1].ovf | wsat[2].ovf | wsat[3].ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1  <= req_valid;
      op1     <= req.operation;
      prod1   <= prod_next;
      b1[0]   <= req.b_x;
      b1[1]   <= req.b_y;
      b1[2]   <= req.b_z;
      simple1 <= simple_next;
    end
  end

  // stage 2: product p[i][j] sits at index 4*i+j, x=0 y=1 z=2 w=3
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pe[k] = qfa_sum_t'(prod1[k]);
    end
    sums_next.valid     = valid1;
    sums_next.operation = op1;
    sums_next.sums      = '0;
    sums_next.b_x       = b1[0];
    sums_next.b_y       = b1[1];
    sums_next.b_z       = b1[2];
    sums_next.simple    = simple1;
    case (op1)
      OP_MUL: begin
        sums_next.sums[0] = pe[3] + pe[12] + pe[6] - pe[9];
        sums_next.sums[1] = pe[13] - pe[2] + pe[7] + pe[8];
        sums_next.sums[2] = pe[14] + pe[1] - pe[4] + pe[11];
        sums_next.sums[3] = pe[15] - pe[0] - pe[5] - pe[10];
      end
      OP_DOT: begin
        sums_next.sums[3] = pe[0] + pe[5] + pe[10] + pe[15];
      end
      OP_SCALE: begin
        sums_next.sums[0] = pe[3];
        sums_next.sums[1] = pe[7];
        sums_next.sums[2] = pe[11];
        sums_next.sums[3] = pe[15];
      end
      OP_ROTATE: begin
        // xx=0 yy=5 zz=10 ww=15 xy=1 xz=2 yz=6 wx=12 wy=13 wz=14
        sums_next.sums[0] = pe[15] + pe[0] - pe[5] - pe[10];
        sums_next.sums[1] = (pe[1] - pe[14]) <<< 1;
        sums_next.sums[2] = (pe[2] + pe[13]) <<< 1;
        sums_next.sums[3] = (pe[1] + pe[14]) <<< 1;
        sums_next.sums[4] = pe[15] - pe[0] + pe[5] - pe[10];
        sums_next.sums[5] = (pe[6] - pe[12]) <<< 1;
        sums_next.sums[6] = (pe[2] - pe[13]) <<< 1;
        sums_next.sums[7] = (pe[6] + pe[12]) <<< 1;
        sums_next.sums[8] = pe[15] - pe[0] - pe[5] + pe[10];
      end
      default: begin
        sums_next.sums = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums.valid <= 1'b0;
    end else if (en) begin
      sums <= sums_next;
    end
  end

endmodule

[rtl/quaternion_fixed_alu.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake             Payload
// request  in   req_valid, req_ready  req (qfa_req_t)
// result   out  res_valid, res_ready  res (qfa_res_t)
//
// Six register stages: products, sums, round, matrix products, matrix sums,
// output. One request per cycle unless a held result stalls it; res_valid rises
// from the output register. The stage 1 array of sixteen 16x16 multipliers sets the cycle.
// Reset clears the stage valid bits only.
// A result held with res_ready low freezes every stage and drops req_ready.

module quaternion_fixed_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  qfa_pkg::qfa_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output qfa_pkg::qfa_res_t res
);
  import qfa_pkg::*;

  typedef logic signed [MAT_WIDTH+DATA_WIDTH-1:0] qfa_mprod_t;

  logic           en;
  qfa_sum_stage_t st2;

  qfa_rnd_t     rnd3 [9];
  qfa_mat_sat_t msat3 [9];
  qfa_sat_t     dsat3 [4];
  qfa_res_t     res3_next;
  qfa_mat_t     mat3_next [9];
  logic         movf3_next;

  logic      valid3;
  logic      rot3;
  qfa_res_t  res3;
  qfa_mat_t  mat3 [9];
  logic      movf3;
  qfa_data_t b3 [3];

  qfa_mprod_t prod4_next [9];
  logic       valid4;
  logic       rot4;
  qfa_res_t   res4;
  logic       movf4;
  qfa_mprod_t prod4 [9];

  qfa_sum_t sum5_next [3];
  logic     valid5;
  logic     rot5;
  qfa_res_t res5;
  logic     movf5;
  qfa_sum_t sum5 [3];

  qfa_sat_t rsat6 [3];
  qfa_res_t res_next;

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  qfa_prod_sum u_prod_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .sums      (st2)
  );

  // stage 3: round all sums; matrix entries for rotate, results otherwise
  always_comb begin
    movf3_next = 1'b0;
    for (int k = 0; k < 9; k++) begin
      rnd3[k]      = round_half_up(st2.sums[k]);
      msat3[k]     = sat_mat(rnd3[k]);
      mat3_next[k] = msat3[k].value;
      movf3_next   = movf3_next | msat3[k].ovf;
    end
    for (int k = 0; k < 4; k++) begin
      dsat3[k] = sat_data(rnd3[k]);
    end
    if (st2.operation inside {OP_MUL, OP_DOT, OP_SCALE}) begin
      res3_next.r_x      = dsat3[0].value;
      res3_next.r_y      = dsat3[1].value;
      res3_next.r_z      = dsat3[2].value;
      res3_next.r_w      = dsat3[3].value;
      res3_next.overflow = dsat3[0].ovf | dsat3[1].ovf | dsat3[2].ovf | dsat3[3].ovf;
    end else begin
      res3_next = st2.simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (en) begin
      valid3 <= st2.valid;
      rot3   <= (st2.operation == OP_ROTATE);
      res3   <= res3_next;
      mat3   <= mat3_next;
      movf3  <= movf3_next;
      b3[0]  <= st2.b_x;
      b3[1]  <= st2.b_y;
      b3[2]  <= st2.b_z;
    end
  end

  // stage 4: matrix times vector, row i at entries 3*i..3*i+2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod4_next[3*i+k] = qfa_mprod_t'(mat3[3*i+k]) * qfa_mprod_t'(b3[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else if (en) begin
      valid4 <= valid3;
      rot4   <= rot3;
      res4   <= res3;
      movf4  <= movf3;
      prod4  <= prod4_next;
    end
  end

  // stage 5: row sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum5_next[i] = qfa_sum_t'(prod4[3*i]) + qfa_sum_t'(prod4[3*i+1])
                   + qfa_sum_t'(prod4[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (en) begin
      valid5 <= valid4;
      rot5   <= rot4;
      res5   <= res4;
      movf5  <= movf4;
      sum5   <= sum5_next;
    end
  end

  // stage 6: round rotated vector, output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsat6[i] = sat_data(round_half_up(sum5[i]));
    end
    if (rot5) begin
      res_next.r_x      = rsat6[0].value;
      res_next.r_y      = rsat6[1].value;
      res_next.r_z      = rsat6[2].value;
      res_next.r_w      = '0;
      res_next.overflow = movf5 | rsat6[0].ovf | rsat6[1].ovf | rsat6[2].ovf;
    end else begin
      res_next = res5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= valid5;
      res       <= res_next;
    end
  end

endmodule

[rtl/qfa_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qfa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input qfa_pkg::qfa_req_t req,
  input logic              res_valid,
  input logic              res_ready,
  input qfa_pkg::qfa_res_t res
);
  import qfa_pkg::*;

  `QFA_ASSERT_ALWAYS(res_clear_after_rst, clk, rst |=> !res_valid)
  `QFA_ASSERT(res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res))
  `QFA_ASSERT(stall_blocks_req, clk, rst, res_valid && !res_ready |-> !req_ready)
  `QFA_ASSERT(empty_takes_req, clk, rst, !res_valid |-> req_ready)
  `QFA_ASSERT(six_cycle_latency, clk, rst, (req_valid && req_ready) ##1 res_ready ##1 res_ready ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)

endmodule

bind quaternion_fixed_alu qfa_checker u_qfa_checker (.*);
